// ----- sv/quadrotor_attitude_pid_mixer_defines.svh -----
// ----------------------------------------------------------------------------
// Quadrotor attitude PID mixer - assertion macros
// Shorthand for clocked assertions, reset-qualified on arst_n, sampled on clk.
// ----------------------------------------------------------------------------
`ifndef QUADROTOR_ATTITUDE_PID_MIXER_DEFINES_SVH
`define QUADROTOR_ATTITUDE_PID_MIXER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define QAPM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QAPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/qapm_pkg.sv -----
// ----------------------------------------------------------------------------
// qapm_pkg
// Widths, fixed-point scaling and register indexes of the attitude PID mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qapm_pkg;

	// field widths
	localparam int ANGLE_W = 16;
	localparam int ERR_W   = ANGLE_W + 1;
	localparam int GAIN_W  = 16;
	localparam int PWM_W   = 12;
	localparam int LIMIT_W = 23;
	localparam int INTEG_W = 24;
	localparam int TERM_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// fixed point: angles 1/16 degree, gains Q8.8
	localparam int ANGLE_FRAC_BITS = 4;
	localparam int GAIN_FRAC_BITS  = 8;
	localparam int SCALE_SHIFT     = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

	localparam int TRIP_DEG  = 55;
	localparam int INTEG_DEG = 20;

	// register reset values
	localparam logic [GAIN_W-1:0]  GAIN_P_RST     = GAIN_W'(794);
	localparam logic [GAIN_W-1:0]  GAIN_I_RST     = GAIN_W'(31);
	localparam logic [GAIN_W-1:0]  GAIN_D_RST     = GAIN_W'(166);
	localparam logic [GAIN_W-1:0]  GAIN_YAW_P_RST = GAIN_W'(2048);
	localparam logic [PWM_W-1:0]   MAX_PWM_RST    = PWM_W'(2000);
	localparam logic [LIMIT_W-1:0] INTEG_LIM_RST  = LIMIT_W'(8000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P,
		CFG_GAIN_I,
		CFG_GAIN_D,
		CFG_GAIN_YAW_P,
		CFG_MAX_PWM,
		CFG_PITCH_LIMIT,
		CFG_ROLL_LIMIT
	} cfg_index_t;

endpackage

`default_nettype wire

// ----- sv/quadrotor_attitude_pid_mixer.sv -----
// ----------------------------------------------------------------------------
// quadrotor_attitude_pid_mixer
// Pitch/roll PI controller with gyro damping, P-only yaw, and an X-layout
// motor mixer with over-angle trip. One control tick per transfer.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  item      item_valid / item_stall    target_*, meas_*, rate_x/y, throttle, armed
//  result    result_valid / result_stall motor_front_a/b, motor_rear_a/b, tripped
//  cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  Throughput is one tick per cycle while no result stall holds the pipeline. An
//  item moves through the input, stage-2, stage-3 and result registers in turn.
//  The pitch/roll integrator loop (error, integrate, clamp) closes through one
//  register with combinational logic ahead of it, which sets this rate.
//  Reset (arst_n low) empties the pipeline, zeroes both integrators and loads
//  the register defaults. A stalled result holds the output register; full stages
//  advance into empty ones, so items are taken while a result waits and a stage is empty.
//  cfg_ready is always high; write registers only while no tick is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quadrotor_attitude_pid_mixer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 item_valid,
	output      logic                                 item_stall,
	input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  target_pitch,
	input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  target_roll,
	input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  target_yaw,
	input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  meas_pitch,
	input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  meas_roll,
	input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  meas_yaw,
	input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  rate_x,
	input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  rate_y,
	input  wire logic        [qapm_pkg::PWM_W-1:0]    throttle,
	input  wire logic                                 armed,

	output      logic                                 result_valid,
	input  wire logic                                 result_stall,
	output      logic        [qapm_pkg::PWM_W-1:0]    motor_front_a,
	output      logic        [qapm_pkg::PWM_W-1:0]    motor_front_b,
	output      logic        [qapm_pkg::PWM_W-1:0]    motor_rear_a,
	output      logic        [qapm_pkg::PWM_W-1:0]    motor_rear_b,
	output      logic                                 tripped,

	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic        [qapm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [qapm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ERR_W   = qapm_pkg::ERR_W;
	localparam int GAIN_W  = qapm_pkg::GAIN_W;
	localparam int PWM_W   = qapm_pkg::PWM_W;
	localparam int LIMIT_W = qapm_pkg::LIMIT_W;
	localparam int INTEG_W = qapm_pkg::INTEG_W;
	localparam int TERM_W  = qapm_pkg::TERM_W;
	localparam int ANGLE_W = qapm_pkg::ANGLE_W;
	localparam int SHIFT   = qapm_pkg::SCALE_SHIFT;

	// error magnitude needs ERR_W-1 bits unsigned
	localparam int MAG_W = ERR_W - 1;
	localparam logic [MAG_W-1:0] TRIP_LIM  =
		MAG_W'(qapm_pkg::TRIP_DEG << qapm_pkg::ANGLE_FRAC_BITS);
	localparam logic [MAG_W-1:0] INTEG_LIM =
		MAG_W'(qapm_pkg::INTEG_DEG << qapm_pkg::ANGLE_FRAC_BITS);

	// product widths: unsigned gain taken as signed GAIN_W+1 bits
	localparam int PE_W  = GAIN_W + 1 + ERR_W;    // gain * error
	localparam int PI_W  = GAIN_W + 1 + INTEG_W;  // gain * integral
	localparam int PR_W  = GAIN_W + 1 + ANGLE_W;  // gain * gyro rate
	localparam int SUM_W = PI_W + 2;
	localparam int ACC_W = INTEG_W + 1;
	localparam int MIX_W = PWM_W + 7;

	localparam logic signed [SUM_W-1:0] TERM_HI = SUM_W'((1 <<< (TERM_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] TERM_LO = SUM_W'(-(1 <<< (TERM_W - 1)));
	localparam logic signed [SUM_W-1:0] ROUND_ADJ = SUM_W'((1 <<< SHIFT) - 1);

	// ------------------------------------------------------------------
	// Arithmetic helpers
	// ------------------------------------------------------------------
	function automatic logic [MAG_W-1:0] err_mag(input logic signed [ERR_W-1:0] e);
		logic signed [ERR_W-1:0] n;
		n = -e;
		return e[ERR_W-1] ? n[MAG_W-1:0] : e[MAG_W-1:0];
	endfunction

	// add error into the integrator, clamp to +/- limit
	function automatic logic signed [INTEG_W-1:0] integrate(
		input logic signed [INTEG_W-1:0] acc,
		input logic signed [ERR_W-1:0]   err,
		input logic        [LIMIT_W-1:0] lim
	);
		logic signed [ACC_W-1:0] s;
		logic signed [ACC_W-1:0] l;
		s = ACC_W'(acc) + ACC_W'(err);
		l = $signed({{(ACC_W - LIMIT_W){1'b0}}, lim});
		if (s >= l)
			s = l;
		else if (s <= -l)
			s = -l;
		return s[INTEG_W-1:0];
	endfunction

	// shift right truncating toward zero, then saturate
	function automatic logic signed [TERM_W-1:0] scale_term(
		input logic signed [SUM_W-1:0] sum
	);
		logic signed [SUM_W-1:0] adj;
		logic signed [SUM_W-1:0] q;
		adj = sum + (sum[SUM_W-1] ? ROUND_ADJ : $signed(SUM_W'(0)));
		q   = adj >>> SHIFT;
		if (q > TERM_HI)
			q = TERM_HI;
		else if (q < TERM_LO)
			q = TERM_LO;
		return q[TERM_W-1:0];
	endfunction

	function automatic logic [PWM_W-1:0] motor_clamp(
		input logic signed [MIX_W-1:0] v,
		input logic        [PWM_W-1:0] top
	);
		logic signed [MIX_W-1:0] t;
		t = $signed({{(MIX_W - PWM_W){1'b0}}, top});
		if (v < 0)
			return '0;
		else if (v >= t)
			return top;
		else
			return v[PWM_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q, gain_yaw_p_q;
	logic [PWM_W-1:0]   max_pwm_q;
	logic [LIMIT_W-1:0] pitch_limit_q, roll_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= qapm_pkg::GAIN_P_RST;
			gain_i_q      <= qapm_pkg::GAIN_I_RST;
			gain_d_q      <= qapm_pkg::GAIN_D_RST;
			gain_yaw_p_q  <= qapm_pkg::GAIN_YAW_P_RST;
			max_pwm_q     <= qapm_pkg::MAX_PWM_RST;
			pitch_limit_q <= qapm_pkg::INTEG_LIM_RST;
			roll_limit_q  <= qapm_pkg::INTEG_LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qapm_pkg::CFG_GAIN_P:      gain_p_q      <= cfg_data[GAIN_W-1:0];
				qapm_pkg::CFG_GAIN_I:      gain_i_q      <= cfg_data[GAIN_W-1:0];
				qapm_pkg::CFG_GAIN_D:      gain_d_q      <= cfg_data[GAIN_W-1:0];
				qapm_pkg::CFG_GAIN_YAW_P:  gain_yaw_p_q  <= cfg_data[GAIN_W-1:0];
				qapm_pkg::CFG_MAX_PWM:     max_pwm_q     <= cfg_data[PWM_W-1:0];
				qapm_pkg::CFG_PITCH_LIMIT: pitch_limit_q <= cfg_data[LIMIT_W-1:0];
				qapm_pkg::CFG_ROLL_LIMIT:  roll_limit_q  <= cfg_data[LIMIT_W-1:0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage loads when the next one is empty or
	// is itself loading, so bubbles collapse under a stalled output.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, result_valid_q;
	logic out_free, free_s3, free_s2, free_s1;
	logic load_out, load_s3, load_s2, accept;

	assign out_free   = !result_valid_q || !result_stall;
	assign load_out   = valid_s3 && out_free;
	assign free_s3    = !valid_s3 || load_out;
	assign load_s3    = valid_s2 && free_s3;
	assign free_s2    = !valid_s2 || load_s3;
	assign load_s2    = valid_s1 && free_s2;
	assign free_s1    = !valid_s1 || load_s2;
	assign accept     = item_valid && free_s1;
	assign item_stall = !free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (free_s1)
				valid_s1 <= item_valid;
			if (free_s2)
				valid_s2 <= valid_s1;
			if (free_s3)
				valid_s3 <= valid_s2;
			if (out_free)
				result_valid_q <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic signed [ANGLE_W-1:0] tgt_pitch_s1, tgt_roll_s1, tgt_yaw_s1;
	logic signed [ANGLE_W-1:0] meas_pitch_s1, meas_roll_s1, meas_yaw_s1;
	logic signed [ANGLE_W-1:0] rate_x_s1, rate_y_s1;
	logic        [PWM_W-1:0]   throttle_s1;
	logic                      armed_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_pitch_s1  <= target_pitch;
			tgt_roll_s1   <= target_roll;
			tgt_yaw_s1    <= target_yaw;
			meas_pitch_s1 <= meas_pitch;
			meas_roll_s1  <= meas_roll;
			meas_yaw_s1   <= meas_yaw;
			rate_x_s1     <= rate_x;
			rate_y_s1     <= rate_y;
			throttle_s1   <= throttle;
			armed_s1      <= armed;
		end
	end

	// ------------------------------------------------------------------
	// Errors, trip check and integrator update. Integrators advance only
	// when the item moves on, so each tick updates them exactly once.
	// ------------------------------------------------------------------
	logic signed [ERR_W-1:0]   err_p, err_r, err_y;
	logic        [MAG_W-1:0]   mag_p, mag_r;
	logic                      trip;
	logic signed [INTEG_W-1:0] pitch_integ_q, roll_integ_q;
	logic signed [INTEG_W-1:0] pitch_integ_d, roll_integ_d;

	always_comb begin
		err_p = ERR_W'(tgt_pitch_s1) - ERR_W'(meas_pitch_s1);
		err_r = ERR_W'(tgt_roll_s1)  - ERR_W'(meas_roll_s1);
		err_y = ERR_W'(tgt_yaw_s1)   - ERR_W'(meas_yaw_s1);
		mag_p = err_mag(err_p);
		mag_r = err_mag(err_r);
		trip  = (mag_p >= TRIP_LIM) || (mag_r >= TRIP_LIM);

		pitch_integ_d = pitch_integ_q;
		roll_integ_d  = roll_integ_q;
		// hold both integrators on a trip; integrate only inside the band
		if (!trip) begin
			if (mag_p <= INTEG_LIM)
				pitch_integ_d = integrate(pitch_integ_q, err_p, pitch_limit_q);
			if (mag_r <= INTEG_LIM)
				roll_integ_d = integrate(roll_integ_q, err_r, roll_limit_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_integ_q <= '0;
			roll_integ_q  <= '0;
		end else if (load_s2) begin
			pitch_integ_q <= pitch_integ_d;
			roll_integ_q  <= roll_integ_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: errors and fresh integrator values
	// ------------------------------------------------------------------
	logic signed [ERR_W-1:0]   err_p_s2, err_r_s2, err_y_s2;
	logic signed [ANGLE_W-1:0] rate_x_s2, rate_y_s2;
	logic signed [INTEG_W-1:0] pitch_integ_s2, roll_integ_s2;
	logic        [PWM_W-1:0]   throttle_s2;
	logic                      armed_s2, trip_s2;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			err_p_s2       <= err_p;
			err_r_s2       <= err_r;
			err_y_s2       <= err_y;
			rate_x_s2      <= rate_x_s1;
			rate_y_s2      <= rate_y_s1;
			pitch_integ_s2 <= pitch_integ_d;
			roll_integ_s2  <= roll_integ_d;
			throttle_s2    <= throttle_s1;
			armed_s2       <= armed_s1;
			trip_s2        <= trip;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: gain products
	// ------------------------------------------------------------------
	logic signed [PE_W-1:0] prod_pp, prod_rp, prod_y;
	logic signed [PI_W-1:0] prod_pi, prod_ri;
	logic signed [PR_W-1:0] prod_pd, prod_rd;

	assign prod_pp = $signed({1'b0, gain_p_q})     * err_p_s2;
	assign prod_rp = $signed({1'b0, gain_p_q})     * err_r_s2;
	assign prod_y  = $signed({1'b0, gain_yaw_p_q}) * err_y_s2;
	assign prod_pi = $signed({1'b0, gain_i_q})     * pitch_integ_s2;
	assign prod_ri = $signed({1'b0, gain_i_q})     * roll_integ_s2;
	assign prod_pd = $signed({1'b0, gain_d_q})     * rate_x_s2;
	assign prod_rd = $signed({1'b0, gain_d_q})     * rate_y_s2;

	logic signed [PE_W-1:0] prod_pp_s3, prod_rp_s3, prod_y_s3;
	logic signed [PI_W-1:0] prod_pi_s3, prod_ri_s3;
	logic signed [PR_W-1:0] prod_pd_s3, prod_rd_s3;
	logic        [PWM_W-1:0] throttle_s3;
	logic                    armed_s3, trip_s3;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			prod_pp_s3  <= prod_pp;
			prod_rp_s3  <= prod_rp;
			prod_y_s3   <= prod_y;
			prod_pi_s3  <= prod_pi;
			prod_ri_s3  <= prod_ri;
			prod_pd_s3  <= prod_pd;
			prod_rd_s3  <= prod_rd;
			throttle_s3 <= throttle_s2;
			armed_s3    <= armed_s2;
			trip_s3     <= trip_s2;
		end
	end

	// ------------------------------------------------------------------
	// Term sums, scaling and X mixer
	// ------------------------------------------------------------------
	logic signed [SUM_W-1:0]  sum_p, sum_r, sum_y;
	logic signed [TERM_W-1:0] term_p, term_r, term_y;
	logic signed [MIX_W-1:0]  base, tp, tr, ty;
	logic        [PWM_W-1:0]  mot_fa, mot_fb, mot_ra, mot_rb;
	logic                     drive;

	always_comb begin
		sum_p  = SUM_W'(prod_pp_s3) + SUM_W'(prod_pi_s3) - SUM_W'(prod_pd_s3);
		sum_r  = SUM_W'(prod_rp_s3) + SUM_W'(prod_ri_s3) - SUM_W'(prod_rd_s3);
		sum_y  = SUM_W'(prod_y_s3);
		term_p = scale_term(sum_p);
		term_r = scale_term(sum_r);
		term_y = scale_term(sum_y);

		base = $signed({{(MIX_W - PWM_W){1'b0}}, throttle_s3});
		tp   = MIX_W'(term_p);
		tr   = MIX_W'(term_r);
		ty   = MIX_W'(term_y);

		// disarmed or tripped: all motors off
		drive  = armed_s3 && !trip_s3;
		mot_fa = drive ? motor_clamp(base + tp + tr + ty, max_pwm_q) : '0;
		mot_fb = drive ? motor_clamp(base - tp + tr - ty, max_pwm_q) : '0;
		mot_ra = drive ? motor_clamp(base - tp - tr + ty, max_pwm_q) : '0;
		mot_rb = drive ? motor_clamp(base + tp - tr - ty, max_pwm_q) : '0;
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [PWM_W-1:0] motor_fa_q, motor_fb_q, motor_ra_q, motor_rb_q;
	logic             tripped_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			motor_fa_q <= mot_fa;
			motor_fb_q <= mot_fb;
			motor_ra_q <= mot_ra;
			motor_rb_q <= mot_rb;
			tripped_q  <= armed_s3 && trip_s3;
		end
	end

	assign result_valid  = result_valid_q;
	assign motor_front_a = motor_fa_q;
	assign motor_front_b = motor_fb_q;
	assign motor_rear_a  = motor_ra_q;
	assign motor_rear_b  = motor_rb_q;
	assign tripped       = tripped_q;

endmodule

`default_nettype wire

// ----- sv/qapm_checker.sv -----
// ----------------------------------------------------------------------------
// qapm_checker
// Port-level checks of the attitude PID mixer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quadrotor_attitude_pid_mixer_defines.svh"

module qapm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          item_valid,
	input wire logic                          item_stall,
	input wire logic                          result_valid,
	input wire logic                          result_stall,
	input wire logic [qapm_pkg::PWM_W-1:0]    motor_front_a,
	input wire logic [qapm_pkg::PWM_W-1:0]    motor_front_b,
	input wire logic [qapm_pkg::PWM_W-1:0]    motor_rear_a,
	input wire logic [qapm_pkg::PWM_W-1:0]    motor_rear_b,
	input wire logic                          tripped
);

	logic [4*qapm_pkg::PWM_W:0] result_bus;
	logic                       motors_off;
	logic                       in_wait;
	logic                       out_wait;

	assign result_bus = {motor_front_a, motor_front_b, motor_rear_a, motor_rear_b, tripped};
	assign motors_off = ~|result_bus[4*qapm_pkg::PWM_W:1];
	assign in_wait    = item_valid && item_stall;
	assign out_wait   = result_valid && result_stall;

	// a stalled result holds until transferred
	`QAPM_ASSERT_NEXT(a_hold, out_wait, result_valid && $stable(result_bus), "held result changed")

	// with the output empty nothing downstream can block intake
	`QAPM_ASSERT_SAME(a_empty_no_stall, !result_valid, !item_stall, "stall with empty output")

	// a trip forces every motor off
	`QAPM_ASSERT_SAME(a_trip_off, result_valid && tripped, motors_off, "motor on while tripped")

	// an input held off only while a result waits in the stalled output
	`QAPM_ASSERT_SAME(a_stall_cause, in_wait, out_wait, "input stalled with no back-pressure")

endmodule

bind quadrotor_attitude_pid_mixer qapm_checker u_qapm_checker (.*);

`default_nettype wire
